### hw/rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse pipeline.
package mi3_pkg;

   // Status of one quotient lane
   typedef struct packed {
      logic singular;
      logic clipped;
   } lane_flag_type;

   // Element indices of each cofactor c[k] = a[p0]*a[p1] - a[s0]*a[s1]
   localparam logic [3:0] CofIdx [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage

### hw/rtl/matrix_inverse_3x3.sv
// Throughput: one request per cycle while the output is not stalled; nine
// divider lanes each resolve one quotient bit per stage, so the lane depth
// sets the latency.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset clears only the valid chain; payload registers are not reset.
module matrix_inverse_3x3 #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ELEM_WIDTH-1:0] req_a00,
   input  logic [ELEM_WIDTH-1:0] req_a01,
   input  logic [ELEM_WIDTH-1:0] req_a02,
   input  logic [ELEM_WIDTH-1:0] req_a10,
   input  logic [ELEM_WIDTH-1:0] req_a11,
   input  logic [ELEM_WIDTH-1:0] req_a12,
   input  logic [ELEM_WIDTH-1:0] req_a20,
   input  logic [ELEM_WIDTH-1:0] req_a21,
   input  logic [ELEM_WIDTH-1:0] req_a22,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ELEM_WIDTH-1:0] rsp_inv00,
   output logic [ELEM_WIDTH-1:0] rsp_inv01,
   output logic [ELEM_WIDTH-1:0] rsp_inv02,
   output logic [ELEM_WIDTH-1:0] rsp_inv10,
   output logic [ELEM_WIDTH-1:0] rsp_inv11,
   output logic [ELEM_WIDTH-1:0] rsp_inv12,
   output logic [ELEM_WIDTH-1:0] rsp_inv20,
   output logic [ELEM_WIDTH-1:0] rsp_inv21,
   output logic [ELEM_WIDTH-1:0] rsp_inv22,
   output logic                  rsp_singular,
   output logic                  rsp_saturated
);

   localparam int W   = ELEM_WIDTH;
   localparam int LAT = ELEM_WIDTH + 8;

   // stage map: products, cofactors, det partials, det terms, det,
   // magnitudes, range check, W quotient steps, output register

   logic                 adv;
   logic [LAT-1:0]       vld_in, vld_ff;

   logic signed [W-1:0]   a      [9];
   logic signed [2*W:0]   cof_s2 [9];
   logic signed [W-1:0]   row0   [3];
   logic signed [3*W+2:0] det;
   logic signed [2*W:0]   cof_s5 [9];
   logic [W-1:0]          res    [9];
   mi3_pkg::lane_flag_type flag  [9];
   logic                  any_clip;

   // whole pipe advances unless the result register is full and stalled
   assign adv       = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !adv;

   assign vld_in = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign a[0] = req_a00;
   assign a[1] = req_a01;
   assign a[2] = req_a02;
   assign a[3] = req_a10;
   assign a[4] = req_a11;
   assign a[5] = req_a12;
   assign a[6] = req_a20;
   assign a[7] = req_a21;
   assign a[8] = req_a22;

   mi3_cofactor #(.W(W)) u_cofactor (
      .clock  (clock),
      .adv    (adv),
      .a_i    (a),
      .cof_o  (cof_s2),
      .row0_o (row0)
   );

   mi3_det #(.W(W)) u_det (
      .clock  (clock),
      .adv    (adv),
      .row0_i (row0),
      .cof_i  (cof_s2),
      .det_o  (det),
      .cof_o  (cof_s5)
   );

   // lane i*3+j gives inverse (i,j) from cofactor (j,i): adjugate transpose
   for (genvar l = 0; l < 9; l++) begin : g_lane
      localparam int R = l / 3;
      localparam int C = l % 3;
      mi3_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
         .clock  (clock),
         .adv    (adv),
         .cof_i  (cof_s5[C*3+R]),
         .det_i  (det),
         .res_o  (res[l]),
         .flag_o (flag[l])
      );
   end

   always_comb begin
      any_clip = 1'b0;
      for (int k = 0; k < 9; k++) begin
         any_clip = any_clip | flag[k].clipped;
      end
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_inv00     = res[0];
   assign rsp_inv01     = res[1];
   assign rsp_inv02     = res[2];
   assign rsp_inv10     = res[3];
   assign rsp_inv11     = res[4];
   assign rsp_inv12     = res[5];
   assign rsp_inv20     = res[6];
   assign rsp_inv21     = res[7];
   assign rsp_inv22     = res[8];
   assign rsp_singular  = flag[0].singular;
   assign rsp_saturated = any_clip;

`ifndef SYNTHESIS
   a_stall_needs_result: assert property (@(posedge clock)
      req_stall |-> rsp_valid)
      else $error("request stalled with no result waiting");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (!rsp_saturated && rsp_inv00 == '0 &&
                                        rsp_inv11 == '0 && rsp_inv22 == '0))
      else $error("singular result not cleared");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

### hw/rtl/mi3_cofactor.sv
// Cofactor stages: 2x2 products, then their differences.
module mi3_cofactor #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                adv,
   input  logic signed [W-1:0] a_i    [9],
   output logic signed [2*W:0] cof_o  [9],
   output logic signed [W-1:0] row0_o [3]
);

   logic signed [2*W-1:0] prod_in [18];
   logic signed [2*W-1:0] prod_ff [18];
   logic signed [2*W:0]   cof_in  [9];
   logic signed [2*W:0]   cof_ff  [9];
   logic signed [W-1:0]   row_d1_ff [3];
   logic signed [W-1:0]   row_d2_ff [3];

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         prod_in[2*k]   = a_i[mi3_pkg::CofIdx[k][0]] * a_i[mi3_pkg::CofIdx[k][1]];
         prod_in[2*k+1] = a_i[mi3_pkg::CofIdx[k][2]] * a_i[mi3_pkg::CofIdx[k][3]];
      end
      for (int k = 0; k < 9; k++) begin
         cof_in[k] = (2*W+1)'(prod_ff[2*k]) - (2*W+1)'(prod_ff[2*k+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         cof_ff  <= cof_in;
         for (int k = 0; k < 3; k++) begin
            row_d1_ff[k] <= a_i[k];
            row_d2_ff[k] <= row_d1_ff[k];
         end
      end
   end

   assign cof_o  = cof_ff;
   assign row0_o = row_d2_ff;

endmodule

### hw/rtl/mi3_det.sv
// Determinant stages: split products, term assembly, three-way sum.
module mi3_det #(
   parameter int W = 32
) (
   input  logic                      clock,
   input  logic                      adv,
   input  logic signed [W-1:0]       row0_i [3],
   input  logic signed [2*W:0]       cof_i  [9],
   output logic signed [3*W+2:0]     det_o,
   output logic signed [2*W:0]       cof_o  [9]
);

   localparam int CW = 2*W + 1;
   localparam int DW = 3*W + 3;

   logic signed [CW-1:0] plo_in [3];
   logic signed [CW-1:0] plo_ff [3];
   logic signed [CW-1:0] phi_in [3];
   logic signed [CW-1:0] phi_ff [3];
   logic signed [DW-1:0] term_in [3];
   logic signed [DW-1:0] term_ff [3];
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det_ff;
   logic signed [CW-1:0] cd1_ff [9];
   logic signed [CW-1:0] cd2_ff [9];
   logic signed [CW-1:0] cd3_ff [9];

   // cofactor split into unsigned low half and signed high part
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         plo_in[k]  = row0_i[k] * $signed({1'b0, cof_i[k][W-1:0]});
         phi_in[k]  = row0_i[k] * $signed(cof_i[k][CW-1:W]);
         term_in[k] = (DW'(phi_ff[k]) <<< W) + DW'(plo_ff[k]);
      end
      det_in = term_ff[0] + term_ff[1] + term_ff[2];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff  <= plo_in;
         phi_ff  <= phi_in;
         term_ff <= term_in;
         det_ff  <= det_in;
         cd1_ff  <= cof_i;
         cd2_ff  <= cd1_ff;
         cd3_ff  <= cd2_ff;
      end
   end

   assign det_o = det_ff;
   assign cof_o = cd3_ff;

endmodule

### hw/rtl/mi3_div_lane.sv
// One quotient lane: magnitudes, range check, one quotient bit per stage, saturation.
module mi3_div_lane #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic signed [2*W:0]         cof_i,
   input  logic signed [3*W+2:0]       det_i,
   output logic [W-1:0]                res_o,
   output mi3_pkg::lane_flag_type      flag_o
);

   localparam int CW = 2*W + 1;
   localparam int DW = 3*W + 3;
   localparam int NW = 2*W + 2*F;
   localparam int RW = (NW > DW + W) ? NW : DW + W;

   logic [CW-1:0]  cabs;
   logic [2*W-1:0] nmag_in, nmag_ff;
   logic [DW-1:0]  dmag_in, dmag_ff;
   logic           rneg1_ff, zero1_ff;

   logic [RW-1:0]  num;
   logic [RW-1:0]  dsh;

   logic [RW-1:0]  rem_in  [W+1];
   logic [RW-1:0]  rem_ff  [W+1];
   logic [W-1:0]   q_in    [W+1];
   logic [W-1:0]   q_ff    [W+1];
   logic [DW-1:0]  dm_ff   [W+1];
   logic           big_ff  [W+1];
   logic           rneg_ff [W+1];
   logic           zero_ff [W+1];

   logic [W-1:0]   lim, qv, res_in, res_ff;
   logic           clip;
   mi3_pkg::lane_flag_type flag_in, flag_ff;

   // magnitudes and signs
   always_comb begin
      cabs    = cof_i[CW-1] ? CW'(-cof_i) : CW'(cof_i);
      nmag_in = cabs[2*W-1:0];
      dmag_in = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nmag_ff  <= nmag_in;
         dmag_ff  <= dmag_in;
         rneg1_ff <= cof_i[CW-1] ^ det_i[DW-1];
         zero1_ff <= (det_i == '0);
      end
   end

   // quotient of 2^W or more saturates whatever the low bits
   always_comb begin
      num       = RW'(nmag_ff) << (2*F);
      dsh       = RW'(dmag_ff) << W;
      rem_in[0] = num;
      q_in[0]   = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= rem_in[0];
         q_ff[0]    <= q_in[0];
         dm_ff[0]   <= dmag_ff;
         big_ff[0]  <= (num >= dsh);
         rneg_ff[0] <= rneg1_ff;
         zero_ff[0] <= zero1_ff;
      end
   end

   // restoring steps, most significant quotient bit first
   for (genvar s = 1; s <= W; s++) begin : g_step
      localparam int B = W - s;
      logic [RW:0] diff;
      logic        ge;

      always_comb begin
         diff      = {1'b0, rem_ff[s-1]} - ({1'b0, RW'(dm_ff[s-1])} << B);
         ge        = !diff[RW];
         rem_in[s] = ge ? diff[RW-1:0] : rem_ff[s-1];
         q_in[s]   = q_ff[s-1] | (W'(ge) << B);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s]  <= rem_in[s];
            q_ff[s]    <= q_in[s];
            dm_ff[s]   <= dm_ff[s-1];
            big_ff[s]  <= big_ff[s-1];
            rneg_ff[s] <= rneg_ff[s-1];
            zero_ff[s] <= zero_ff[s-1];
         end
      end
   end

   // sign and clip
   always_comb begin
      lim  = rneg_ff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      clip = big_ff[W] || (q_ff[W] > lim);
      qv   = clip ? lim : q_ff[W];
      if (zero_ff[W]) begin
         res_in           = '0;
         flag_in.singular = 1'b1;
         flag_in.clipped  = 1'b0;
      end else begin
         res_in           = rneg_ff[W] ? W'(-qv) : qv;
         flag_in.singular = 1'b0;
         flag_in.clipped  = clip;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff  <= res_in;
         flag_ff <= flag_in;
      end
   end

   assign res_o  = res_ff;
   assign flag_o = flag_ff;

endmodule
